@@ sv/tsa_pkg.sv @@
package tsa_pkg;

  localparam int unsigned CoordW = 12;
  localparam int unsigned DiffW  = CoordW + 1;
  localparam int unsigned SqW    = 2 * DiffW;
  localparam int unsigned D2W    = SqW + 2;
  localparam int unsigned KW     = 2 * DiffW + 1;
  localparam int unsigned KSqW   = 2 * KW - 1;
  localparam int unsigned KSumW  = KSqW + 2;
  localparam int unsigned RootW  = 2 * DiffW + 5;
  localparam int unsigned RadW   = 2 * RootW;
  localparam int unsigned RemW   = RootW + 2;
  localparam int unsigned SideW  = 21;
  localparam int unsigned AreaW  = 29;

  // 8 fraction bits on a side need 16 on its square; area*16 = sqrt(64*|k|^2)
  localparam int unsigned SideShift  = 16;
  localparam int unsigned AreaShift  = 6;
  localparam int unsigned FrontDepth = 5;
  localparam int unsigned NumLanes   = 4;

  localparam int unsigned LaneAb   = 0;
  localparam int unsigned LaneBc   = 1;
  localparam int unsigned LaneCa   = 2;
  localparam int unsigned LaneArea = 3;

  typedef struct packed {
    logic                     mode_3d;
    logic signed [CoordW-1:0] ax;
    logic signed [CoordW-1:0] ay;
    logic signed [CoordW-1:0] az;
    logic signed [CoordW-1:0] bx;
    logic signed [CoordW-1:0] by_coord;
    logic signed [CoordW-1:0] bz;
    logic signed [CoordW-1:0] cx;
    logic signed [CoordW-1:0] cy;
    logic signed [CoordW-1:0] cz;
  } in_t;

  typedef struct packed {
    logic [SideW-1:0] side_ab;
    logic [SideW-1:0] side_bc;
    logic [SideW-1:0] side_ca;
    logic [AreaW-1:0] area;
  } out_t;

endpackage

@@ sv/triangle_sides_and_area.sv @@
// Triangle side lengths and area, one triangle per transfer.
// Input channel: valid_i / stall_o with data_i (mode flag and three points).
// Output channel: valid_o / stall_i with data_o (sides AB, BC, CA with 8
// fraction bits, area with 4 fraction bits, all floored).
// Pipeline: 5 front stages (edge vectors, products, cross vector, squares,
// radicands), 31 square-root cells (one root bit per cell, four lanes side by
// side) and the output register.
// Throughput: one triangle per cycle while the receiver does not stall.
// When stall_i holds a waiting result, the whole pipeline freezes; one more
// input transfer lands in a skid register and stall_o rises the cycle after,
// so stall_o is registered and never follows stall_i combinationally.
// Reset clears all valid flags, the skid flag among them, but not the data; no item is in flight.
module triangle_sides_and_area (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  output logic          stall_o,
  input  tsa_pkg::in_t  data_i,
  output logic          valid_o,
  input  logic          stall_i,
  output tsa_pkg::out_t data_o
);

  localparam int unsigned NStage = tsa_pkg::FrontDepth + tsa_pkg::RootW;

  logic         en;
  logic         skid_v_d, skid_v_q;
  tsa_pkg::in_t skid_q;
  tsa_pkg::in_t src;
  logic         src_v;
  logic [NStage-1:0] vld_d, vld_q;
  logic         out_v_d, out_v_q;
  tsa_pkg::out_t out_d, out_q;

  logic [tsa_pkg::NumLanes-1:0][tsa_pkg::RadW-1:0] rad_front;
  logic [tsa_pkg::RemW-1:0]  rem_c  [tsa_pkg::NumLanes][tsa_pkg::RootW+1];
  logic [tsa_pkg::RootW-1:0] root_c [tsa_pkg::NumLanes][tsa_pkg::RootW+1];
  logic [tsa_pkg::RadW-1:0]  rad_c  [tsa_pkg::NumLanes][tsa_pkg::RootW+1];

  // the whole pipeline moves unless a finished result is held
  assign en    = !(out_v_q && stall_i);
  assign src   = skid_v_q ? skid_q : data_i;
  assign src_v = skid_v_q || valid_i;

  always_comb begin
    skid_v_d = skid_v_q ? !en : (valid_i && !en);
    vld_d    = en ? {vld_q[NStage-2:0], src_v} : vld_q;
    out_v_d  = en ? vld_q[NStage-1] : out_v_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skid_v_q <= 1'b0;
      vld_q    <= '0;
      out_v_q  <= 1'b0;
    end else begin
      skid_v_q <= skid_v_d;
      vld_q    <= vld_d;
      out_v_q  <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!skid_v_q && !en) begin
      skid_q <= data_i;
    end
    if (en) begin
      out_q <= out_d;
    end
  end

  tsa_front u_front (
    .clk_i  (clk_i),
    .en_i   (en),
    .data_i (src),
    .rad_o  (rad_front)
  );

  for (genvar l = 0; l < tsa_pkg::NumLanes; l++) begin : g_lane
    assign rem_c[l][0]  = '0;
    assign root_c[l][0] = '0;
    assign rad_c[l][0]  = rad_front[l];
    for (genvar s = 0; s < tsa_pkg::RootW; s++) begin : g_cell
      tsa_cell u_cell (
        .clk_i  (clk_i),
        .en_i   (en),
        .rem_i  (rem_c[l][s]),
        .root_i (root_c[l][s]),
        .rad_i  (rad_c[l][s]),
        .rem_o  (rem_c[l][s+1]),
        .root_o (root_c[l][s+1]),
        .rad_o  (rad_c[l][s+1])
      );
    end
  end

  // saturate any root that overflows its field
  function automatic logic [tsa_pkg::SideW-1:0] side_sat(
    input logic [tsa_pkg::RootW-1:0] r
  );
    side_sat = (|r[tsa_pkg::RootW-1:tsa_pkg::SideW]) ? '1 : r[tsa_pkg::SideW-1:0];
  endfunction

  always_comb begin
    out_d.side_ab = side_sat(root_c[tsa_pkg::LaneAb][tsa_pkg::RootW]);
    out_d.side_bc = side_sat(root_c[tsa_pkg::LaneBc][tsa_pkg::RootW]);
    out_d.side_ca = side_sat(root_c[tsa_pkg::LaneCa][tsa_pkg::RootW]);
    out_d.area    = (|root_c[tsa_pkg::LaneArea][tsa_pkg::RootW][tsa_pkg::RootW-1:tsa_pkg::AreaW])
                  ? '1 : root_c[tsa_pkg::LaneArea][tsa_pkg::RootW][tsa_pkg::AreaW-1:0];
  end

  assign stall_o = skid_v_q;
  assign valid_o = out_v_q;
  assign data_o  = out_q;

  a_skid_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(stall_o) |-> $past(valid_i && valid_o && stall_i))
    else $error("skid register filled while the pipeline was moving");

  a_skid_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(valid_o && stall_i) |=> !stall_o)
    else $error("skid register not drained when the pipeline moved");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && stall_i |=> valid_o && vld_q == $past(vld_q))
    else $error("pipeline advanced while the result was held");

endmodule

@@ sv/tsa_cell.sv @@
module tsa_cell (
  input  logic                       clk_i,
  input  logic                       en_i,
  input  logic [tsa_pkg::RemW-1:0]   rem_i,
  input  logic [tsa_pkg::RootW-1:0]  root_i,
  input  logic [tsa_pkg::RadW-1:0]   rad_i,
  output logic [tsa_pkg::RemW-1:0]   rem_o,
  output logic [tsa_pkg::RootW-1:0]  root_o,
  output logic [tsa_pkg::RadW-1:0]   rad_o
);

  logic [tsa_pkg::RemW+1:0]  cur;
  logic [tsa_pkg::RemW+1:0]  trial;
  logic                      ge;
  logic [tsa_pkg::RemW-1:0]  rem_d, rem_q;
  logic [tsa_pkg::RootW-1:0] root_d, root_q;
  logic [tsa_pkg::RadW-1:0]  rad_d, rad_q;

  // bring down the next two radicand bits and try root*4+1
  assign cur   = {rem_i, rad_i[tsa_pkg::RadW-1 -: 2]};
  assign trial = (tsa_pkg::RemW+2)'({root_i, 2'b01});
  assign ge    = (cur >= trial);

  always_comb begin
    rem_d  = ge ? tsa_pkg::RemW'(cur - trial) : tsa_pkg::RemW'(cur);
    root_d = {root_i[tsa_pkg::RootW-2:0], ge};
    rad_d  = {rad_i[tsa_pkg::RadW-3:0], 2'b00};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q  <= rem_d;
      root_q <= root_d;
      rad_q  <= rad_d;
    end
  end

  assign rem_o  = rem_q;
  assign root_o = root_q;
  assign rad_o  = rad_q;

endmodule

@@ sv/tsa_front.sv @@
module tsa_front (
  input  logic                                          clk_i,
  input  logic                                          en_i,
  input  tsa_pkg::in_t                                  data_i,
  output logic [tsa_pkg::NumLanes-1:0][tsa_pkg::RadW-1:0] rad_o
);

  localparam int unsigned DW = tsa_pkg::DiffW;
  localparam int unsigned SW = tsa_pkg::SqW;

  logic signed [tsa_pkg::CoordW-1:0] az, bz, cz;
  // stage 1: edge vectors u = B-A, v = C-A, w = C-B
  logic signed [DW-1:0] u_d [3];
  logic signed [DW-1:0] v_d [3];
  logic signed [DW-1:0] w_d [3];
  logic signed [DW-1:0] u_q [3];
  logic signed [DW-1:0] v_q [3];
  logic signed [DW-1:0] w_q [3];
  // stage 2: cross partial products and squares
  logic signed [SW-1:0] cp_d [6];
  logic signed [SW-1:0] cp_q [6];
  logic signed [SW-1:0] sq_s [9];
  logic [SW-1:0]        sq_d [9];
  logic [SW-1:0]        sq_q [9];
  // stage 3: cross vector and squared side lengths
  logic signed [tsa_pkg::KW-1:0] k_d [3];
  logic signed [tsa_pkg::KW-1:0] k_q [3];
  logic [tsa_pkg::D2W-1:0]       d2_d [3];
  logic [tsa_pkg::D2W-1:0]       d2_q [3];
  logic [tsa_pkg::D2W-1:0]       d2_r [3];
  // stage 4: squared cross components
  logic signed [2*tsa_pkg::KW-1:0] ksq_s [3];
  logic [tsa_pkg::KSqW-1:0]        ksq_q [3];
  // stage 5: radicands
  logic [tsa_pkg::KSumW-1:0]                      ksum;
  logic [tsa_pkg::NumLanes-1:0][tsa_pkg::RadW-1:0] rad_d, rad_q;

  assign az = data_i.mode_3d ? data_i.az : '0;
  assign bz = data_i.mode_3d ? data_i.bz : '0;
  assign cz = data_i.mode_3d ? data_i.cz : '0;

  always_comb begin
    u_d[0] = DW'(data_i.bx) - DW'(data_i.ax);
    u_d[1] = DW'(data_i.by_coord) - DW'(data_i.ay);
    u_d[2] = DW'(bz) - DW'(az);
    v_d[0] = DW'(data_i.cx) - DW'(data_i.ax);
    v_d[1] = DW'(data_i.cy) - DW'(data_i.ay);
    v_d[2] = DW'(cz) - DW'(az);
    w_d[0] = DW'(data_i.cx) - DW'(data_i.bx);
    w_d[1] = DW'(data_i.cy) - DW'(data_i.by_coord);
    w_d[2] = DW'(cz) - DW'(bz);
  end

  always_comb begin
    cp_d[0] = u_q[1] * v_q[2];
    cp_d[1] = u_q[2] * v_q[1];
    cp_d[2] = u_q[2] * v_q[0];
    cp_d[3] = u_q[0] * v_q[2];
    cp_d[4] = u_q[0] * v_q[1];
    cp_d[5] = u_q[1] * v_q[0];
    for (int i = 0; i < 3; i++) begin
      sq_s[i]   = u_q[i] * u_q[i];
      sq_s[3+i] = w_q[i] * w_q[i];
      sq_s[6+i] = v_q[i] * v_q[i];
    end
    for (int i = 0; i < 9; i++) begin
      sq_d[i] = sq_s[i];
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      k_d[i]  = tsa_pkg::KW'(cp_q[2*i]) - tsa_pkg::KW'(cp_q[2*i+1]);
      d2_d[i] = tsa_pkg::D2W'(sq_q[3*i]) + tsa_pkg::D2W'(sq_q[3*i+1])
              + tsa_pkg::D2W'(sq_q[3*i+2]);
      ksq_s[i] = k_q[i] * k_q[i];
    end
  end

  always_comb begin
    ksum = tsa_pkg::KSumW'(ksq_q[0]) + tsa_pkg::KSumW'(ksq_q[1])
         + tsa_pkg::KSumW'(ksq_q[2]);
    rad_d[tsa_pkg::LaneAb]   = tsa_pkg::RadW'(d2_r[0]) << tsa_pkg::SideShift;
    rad_d[tsa_pkg::LaneBc]   = tsa_pkg::RadW'(d2_r[1]) << tsa_pkg::SideShift;
    rad_d[tsa_pkg::LaneCa]   = tsa_pkg::RadW'(d2_r[2]) << tsa_pkg::SideShift;
    rad_d[tsa_pkg::LaneArea] = tsa_pkg::RadW'(ksum) << tsa_pkg::AreaShift;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      u_q   <= u_d;
      v_q   <= v_d;
      w_q   <= w_d;
      cp_q  <= cp_d;
      sq_q  <= sq_d;
      k_q   <= k_d;
      d2_q  <= d2_d;
      d2_r  <= d2_q;
      for (int i = 0; i < 3; i++) begin
        ksq_q[i] <= ksq_s[i][tsa_pkg::KSqW-1:0];
      end
      rad_q <= rad_d;
    end
  end

  assign rad_o = rad_q;

endmodule

@@ tb/triangle_sides_and_area_test.sv @@
module triangle_sides_and_area_test;

  localparam int unsigned Latency = 37;
  localparam longint unsigned CycleLimit = 400000;

  // Floor square root by bit-by-bit search on a wide radicand.
  function automatic longint unsigned floor_root(logic [127:0] rad);
    logic [63:0] r;
    logic [63:0] c;
    r = '0;
    for (int b = 40; b >= 0; b--) begin
      c = r | (64'd1 << b);
      if ({64'd0, c} * {64'd0, c} <= rad) r = c;
    end
    return r;
  endfunction

  function automatic tsa_pkg::out_t triangle_result(tsa_pkg::in_t t);
    longint xa, ya, za, xb, yb, zb, xc, yc, zc;
    longint ux, uy, uz, vx, vy, vz, kx, ky, kz;
    longint dab, dbc, dca;
    logic [127:0] ksq;
    tsa_pkg::out_t r;
    xa = t.ax; ya = t.ay; xb = t.bx; yb = t.by_coord; xc = t.cx; yc = t.cy;
    za = t.mode_3d ? longint'(t.az) : 0;
    zb = t.mode_3d ? longint'(t.bz) : 0;
    zc = t.mode_3d ? longint'(t.cz) : 0;
    ux = xb - xa; uy = yb - ya; uz = zb - za;
    vx = xc - xa; vy = yc - ya; vz = zc - za;
    kx = uy * vz - uz * vy;
    ky = uz * vx - ux * vz;
    kz = ux * vy - uy * vx;
    dab = ux * ux + uy * uy + uz * uz;
    dbc = (xc - xb) * (xc - xb) + (yc - yb) * (yc - yb) + (zc - zb) * (zc - zb);
    dca = vx * vx + vy * vy + vz * vz;
    ksq = 128'(kx * kx) + 128'(ky * ky) + 128'(kz * kz);
    r.side_ab = tsa_pkg::SideW'(floor_root(128'(dab) << tsa_pkg::SideShift));
    r.side_bc = tsa_pkg::SideW'(floor_root(128'(dbc) << tsa_pkg::SideShift));
    r.side_ca = tsa_pkg::SideW'(floor_root(128'(dca) << tsa_pkg::SideShift));
    r.area    = tsa_pkg::AreaW'(floor_root(ksq << tsa_pkg::AreaShift));
    return r;
  endfunction

  class triangle_scoreboard;
    tsa_pkg::out_t pending[$];
    int   errors;

    function void note_input(tsa_pkg::in_t t);
      pending.push_back(triangle_result(t));
    endfunction

    function void check_result(tsa_pkg::out_t got);
      tsa_pkg::out_t want;
      if (pending.size() == 0) begin
        $error("result with nothing pending: %h", got);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.side_ab !== want.side_ab) begin
        $error("side_ab expected %0d actual %0d", want.side_ab, got.side_ab);
        errors++;
      end
      if (got.side_bc !== want.side_bc) begin
        $error("side_bc expected %0d actual %0d", want.side_bc, got.side_bc);
        errors++;
      end
      if (got.side_ca !== want.side_ca) begin
        $error("side_ca expected %0d actual %0d", want.side_ca, got.side_ca);
        errors++;
      end
      if (got.area !== want.area) begin
        $error("area expected %0d actual %0d", want.area, got.area);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic valid_i = 1'b0;
  logic stall_i = 1'b0;
  tsa_pkg::in_t  data_i = '0;
  logic stall_o, valid_o;
  tsa_pkg::out_t data_o;
  triangle_scoreboard board = new();
  longint unsigned cycles = 0;
  bit   calm = 1'b0;

  triangle_sides_and_area dut (
    .clk_i, .rst_ni, .valid_i, .stall_o, .data_i, .valid_o, .stall_i, .data_o
  );

  always #10 clk_i = ~clk_i;

  // Check every output transfer and note every input transfer.
  always @(posedge clk_i) begin
    if (rst_ni && valid_o && !stall_i) board.check_result(data_o);
    if (rst_ni && valid_i && !stall_o) board.note_input(data_i);
  end

  // Receiver stalls in random bursts.
  initial begin
    int n;
    forever begin
      @(posedge clk_i);
      if (!calm && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 15);
        stall_i <= 1'b1;
        repeat (n) @(posedge clk_i);
        stall_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic logic [tsa_pkg::CoordW-1:0] pick_coord();
    case ($urandom_range(0, 5))
      0: return {1'b0, {(tsa_pkg::CoordW-1){1'b1}}};
      1: return {1'b1, {(tsa_pkg::CoordW-1){1'b0}}};
      2: return tsa_pkg::CoordW'($urandom_range(0, 15));
      default: return tsa_pkg::CoordW'($urandom);
    endcase
  endfunction

  function automatic tsa_pkg::in_t make_triangle(
    logic m, int ax, int ay, int az, int bx, int by_c, int bz, int cx, int cy, int cz
  );
    tsa_pkg::in_t t;
    t.mode_3d  = m;
    t.ax       = tsa_pkg::CoordW'(ax);
    t.ay       = tsa_pkg::CoordW'(ay);
    t.az       = tsa_pkg::CoordW'(az);
    t.bx       = tsa_pkg::CoordW'(bx);
    t.by_coord = tsa_pkg::CoordW'(by_c);
    t.bz       = tsa_pkg::CoordW'(bz);
    t.cx       = tsa_pkg::CoordW'(cx);
    t.cy       = tsa_pkg::CoordW'(cy);
    t.cz       = tsa_pkg::CoordW'(cz);
    return t;
  endfunction

  function automatic tsa_pkg::in_t random_triangle();
    tsa_pkg::in_t t;
    t.mode_3d = 1'($urandom_range(0, 1));
    t.ax = pick_coord(); t.ay = pick_coord(); t.az = pick_coord();
    t.bx = pick_coord(); t.by_coord = pick_coord(); t.bz = pick_coord();
    t.cx = pick_coord(); t.cy = pick_coord(); t.cz = pick_coord();
    // Make some triangles degenerate: B or C coincides with A.
    case ($urandom_range(0, 9))
      0: begin t.bx = t.ax; t.by_coord = t.ay; t.bz = t.az; end
      1: begin t.cx = t.ax; t.cy = t.ay; t.cz = t.az; end
      default: ;
    endcase
    return t;
  endfunction

  // Hold valid until the transfer, with random gaps between items.
  task automatic send_triangle(tsa_pkg::in_t t);
    if (!calm && $urandom_range(0, 5) == 0) begin
      valid_i <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
    valid_i <= 1'b1;
    data_i  <= t;
    @(posedge clk_i);
    while (stall_o) @(posedge clk_i);
  endtask

  task automatic drain();
    valid_i <= 1'b0;
    @(posedge clk_i);
    while (board.pending.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    tsa_pkg::in_t t;
    logic signed [tsa_pkg::CoordW-1:0] hi, lo;
    logic md;
    hi = {1'b0, {(tsa_pkg::CoordW-1){1'b1}}};
    lo = {1'b1, {(tsa_pkg::CoordW-1){1'b0}}};
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: zeros, extremes, degenerate and right triangles, both modes.
    for (int m = 0; m < 2; m++) begin
      md = m[0];
      t = '0; t.mode_3d = md;
      send_triangle(t);
      t = make_triangle(md, lo, lo, lo, hi, hi, hi, lo, hi, lo); send_triangle(t);
      t = make_triangle(md, hi, hi, hi, lo, lo, lo, hi, lo, hi); send_triangle(t);
      t = make_triangle(md, lo, lo, hi, hi, lo, lo, lo, hi, hi); send_triangle(t);
      t = make_triangle(md, 0, 0, 0, 3, 0, 0, 0, 4, 0); send_triangle(t);
      t = make_triangle(md, 1, 1, 1, 2, 2, 2, 3, 3, 3); send_triangle(t);
      t = make_triangle(md, 5, -7, 9, 5, -7, 9, 5, -7, 9); send_triangle(t);
      t = make_triangle(md, -1, -1, -1, 0, 0, 0, 1, -1, 1); send_triangle(t);
      t = make_triangle(md, hi, lo, 0, lo, hi, 0, 0, 0, hi); send_triangle(t);
      t = make_triangle(md, 0, 0, lo, 0, 0, hi, 1, 0, 0); send_triangle(t);
      t = make_triangle(md, -1, -1, -1, -1, -1, -1, -1, -1, -1); send_triangle(t);
    end

    for (int i = 0; i < 600; i++) begin
      if (i == 300) drain();
      if (i == 500) calm = 1'b1;
      send_triangle(random_triangle());
    end
    drain();
    repeat (Latency + 10) @(posedge clk_i);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
